FILE: rtl/core/isl_pkg.sv
package isl_pkg;

   // fixed field widths
   localparam int ADDR_W      = 48;
   localparam int STAMP_W     = 64;
   localparam int PROD_FIELDS = 3;

   // request commands
   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_TRAIN = 1'b1;

   // result of one compare step of the shared way unit
   typedef struct packed {
      logic match;
      logic older;
   } isl_cmp_type;

endpackage

FILE: rtl/core/isl_ram.sv
module isl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/isl_way_unit.sv
module isl_way_unit #(
   parameter int WAYS  = 2,
   parameter int TAG_W = 42,
   parameter int WAY_W = 1
) (
   input  logic [WAYS*(TAG_W+isl_pkg::STAMP_W)-1:0] row,
   input  logic [WAY_W-1:0]                         way_sel,
   input  logic [TAG_W-1:0]                         tag,
   input  logic [isl_pkg::STAMP_W-1:0]              victim_stamp,
   output logic [isl_pkg::STAMP_W-1:0]              way_stamp,
   output isl_pkg::isl_cmp_type                     cmp
);

   import isl_pkg::*;

   localparam int ENT_W = TAG_W + STAMP_W;

   logic [ENT_W-1:0] entry;

   // pick the way under examination
   always_comb begin
      entry = row[ENT_W-1:0];
      for (int w = 0; w < WAYS; w++) begin
         if (way_sel == WAY_W'(w)) begin
            entry = row[w*ENT_W +: ENT_W];
         end
      end
   end

   // tag match and stamp age compare
   assign way_stamp = entry[STAMP_W-1:0];
   assign cmp.match = (entry[ENT_W-1:STAMP_W] == tag);
   assign cmp.older = (entry[STAMP_W-1:0] < victim_stamp);

endmodule

FILE: rtl/core/instruction_slice_table_core.sv
// Instruction slice table: set-associative table of instruction addresses with
// least-recently-used replacement.
// Request channel (req_*): one micro-op with its command, address, load/store
// flags and up to three producer addresses. Response channel (rsp_*): one
// in_slice bit per request, the prediction made before any training.
// Each address touched costs one row read, a scan of the ways through a single
// shared tag/stamp compare unit (one way per cycle, stopping on a hit) and,
// when it trains, one row write. A request touches one address for a query and
// up to four when it trains; the response waits until every address touched
// has been scanned. One request is in work at a time; req_ready is high only
// while the sequencer is idle, which it enters at the same edge that loads
// the response.
// The response sits in an output register; a new request is accepted while it
// waits, and a finished request holds in its last step until rsp_ready frees
// the register.
// After reset a clearing pass writes zero to every row of the table, one row a
// cycle, during which req_ready stays low.
module instruction_slice_table_core #(
   parameter int SET_BITS    = 6,
   parameter int WAYS        = 2,
   parameter int MAX_SOURCES = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic [isl_pkg::ADDR_W-1:0]  req_op_addr,
   input  logic                        req_is_load,
   input  logic                        req_is_store,
   input  logic [isl_pkg::ADDR_W-1:0]  req_producer_addr_0,
   input  logic                        req_producer_valid_0,
   input  logic [isl_pkg::ADDR_W-1:0]  req_producer_addr_1,
   input  logic                        req_producer_valid_1,
   input  logic [isl_pkg::ADDR_W-1:0]  req_producer_addr_2,
   input  logic                        req_producer_valid_2,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_in_slice
);

   import isl_pkg::*;

   localparam int NUM_SETS = 2 ** SET_BITS;
   localparam int TAG_W    = ADDR_W - SET_BITS;
   localparam int ENT_W    = TAG_W + STAMP_W;
   localparam int ROW_W    = WAYS * ENT_W;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int NUM_SRC  = (MAX_SOURCES < PROD_FIELDS) ? MAX_SOURCES : PROD_FIELDS;
   localparam int SRC_W    = $clog2(PROD_FIELDS);
   localparam logic [WAY_W-1:0]       LAST_WAY = WAY_W'(WAYS - 1);
   localparam logic [SET_BITS-1:0]    LAST_SET = SET_BITS'(NUM_SETS - 1);
   localparam logic [PROD_FIELDS-1:0] SRC_MASK = PROD_FIELDS'((1 << NUM_SRC) - 1);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_READ   = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [SET_BITS-1:0]      clr_ff, clr_in;
   logic [STAMP_W-1:0]       count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_in_slice_ff, rsp_in_slice_in;
   logic                     cmd_ff, cmd_in;
   logic                     load_ff, load_in;
   logic                     store_ff, store_in;
   logic                     pred_ff, pred_in;
   logic                     first_ff, first_in;
   logic                     hit_ff, hit_in;
   logic [ADDR_W-1:0]        cur_addr_ff, cur_addr_in;
   logic [ADDR_W-1:0]        prod_addr_ff [PROD_FIELDS];
   logic [ADDR_W-1:0]        prod_addr_in [PROD_FIELDS];
   logic [PROD_FIELDS-1:0]   pend_ff, pend_in;
   logic [WAY_W-1:0]         way_ff, way_in;
   logic [WAY_W-1:0]         victim_ff, victim_in;
   logic [WAY_W-1:0]         sel_way_ff, sel_way_in;
   logic [STAMP_W-1:0]       victim_stamp_ff, victim_stamp_in;

   logic                     wr_en;
   logic [SET_BITS-1:0]      wr_addr;
   logic [ROW_W-1:0]         wr_data;
   logic [ROW_W-1:0]         row_mod;
   logic [ROW_W-1:0]         rd_data;
   logic [TAG_W-1:0]         cur_tag;
   logic [STAMP_W-1:0]       way_stamp;
   isl_cmp_type              cmp;
   logic [SRC_W-1:0]         nxt_idx;
   logic                     nxt_found;
   logic                     pred_now;
   logic                     take_victim;

   assign cur_tag = cur_addr_ff[ADDR_W-1:SET_BITS];

   // table rows: all ways of one set side by side
   isl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cur_addr_ff[SET_BITS-1:0]),
      .rd_data (rd_data)
   );

   // shared compare unit, one way per cycle
   isl_way_unit #(
      .WAYS  (WAYS),
      .TAG_W (TAG_W),
      .WAY_W (WAY_W)
   ) u_way (
      .row          (rd_data),
      .way_sel      (way_ff),
      .tag          (cur_tag),
      .victim_stamp (victim_stamp_ff),
      .way_stamp    (way_stamp),
      .cmp          (cmp)
   );

   // row with the chosen way refreshed
   always_comb begin
      row_mod = rd_data;
      for (int w = 0; w < WAYS; w++) begin
         if (sel_way_ff == WAY_W'(w)) begin
            row_mod[w*ENT_W +: ENT_W] = {cur_tag, count_ff};
         end
      end
   end

   // next pending producer, lowest first
   always_comb begin
      nxt_idx   = '0;
      nxt_found = 1'b0;
      for (int i = 0; i < PROD_FIELDS; i++) begin
         if (pend_ff[i] && !nxt_found) begin
            nxt_idx   = SRC_W'(i);
            nxt_found = 1'b1;
         end
      end
   end

   assign pred_now    = first_ff ? (load_ff | (~store_ff & hit_ff)) : pred_ff;
   assign take_victim = (way_ff == '0) || cmp.older;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_in_slice_in = rsp_in_slice_ff;
      cmd_in          = cmd_ff;
      load_in         = load_ff;
      store_in        = store_ff;
      pred_in         = pred_ff;
      first_in        = first_ff;
      hit_in          = hit_ff;
      cur_addr_in     = cur_addr_ff;
      prod_addr_in    = prod_addr_ff;
      pend_in         = pend_ff;
      way_in          = way_ff;
      victim_in       = victim_ff;
      sel_way_in      = sel_way_ff;
      victim_stamp_in = victim_stamp_ff;
      wr_en           = 1'b0;
      wr_addr         = cur_addr_ff[SET_BITS-1:0];
      wr_data         = row_mod;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in          = req_cmd;
               load_in         = req_is_load;
               store_in        = req_is_store;
               cur_addr_in     = req_op_addr;
               prod_addr_in[0] = req_producer_addr_0;
               prod_addr_in[1] = req_producer_addr_1;
               prod_addr_in[2] = req_producer_addr_2;
               pend_in         = {req_producer_valid_2, req_producer_valid_1,
                                  req_producer_valid_0} & SRC_MASK;
               first_in        = 1'b1;
               state_in        = ST_READ;
            end
         end
         ST_READ: begin
            way_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (cmp.match) begin
               hit_in     = 1'b1;
               sel_way_in = way_ff;
               state_in   = ST_UPDATE;
            end else begin
               if (take_victim) begin
                  victim_in       = way_ff;
                  victim_stamp_in = way_stamp;
               end
               if (way_ff == LAST_WAY) begin
                  hit_in     = 1'b0;
                  sel_way_in = take_victim ? way_ff : victim_ff;
                  state_in   = ST_UPDATE;
               end else begin
                  way_in = way_ff + 1'b1;
               end
            end
         end
         ST_UPDATE: begin
            pred_in = pred_now;
            if ((cmd_ff == CMD_TRAIN) && (store_ff || pred_now)) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               first_in = 1'b0;
               if (nxt_found) begin
                  cur_addr_in      = prod_addr_ff[nxt_idx];
                  pend_in[nxt_idx] = 1'b0;
                  state_in         = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_in_slice_in = pred_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_in_slice_ff <= rsp_in_slice_in;
      cmd_ff          <= cmd_in;
      load_ff         <= load_in;
      store_ff        <= store_in;
      pred_ff         <= pred_in;
      first_ff        <= first_in;
      hit_ff          <= hit_in;
      cur_addr_ff     <= cur_addr_in;
      prod_addr_ff    <= prod_addr_in;
      pend_ff         <= pend_in;
      way_ff          <= way_in;
      victim_ff       <= victim_in;
      sel_way_ff      <= sel_way_in;
      victim_stamp_ff <= victim_stamp_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_in_slice = rsp_in_slice_ff;

endmodule

FILE: rtl/core/isl_checker.sv
module isl_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_in_slice
);

   // a stalled response holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_in_slice))
      else $error("response changed while stalled");

   // one request in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   // a new response only comes out of a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared without work behind it");

   // the clearing pass keeps requests out after reset
   assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during table clear");

endmodule

bind instruction_slice_table_core isl_checker u_isl_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_in_slice (rsp_in_slice)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import isl_pkg::*;

   localparam int SET_BITS    = 6;
   localparam int WAYS        = 2;
   localparam int MAX_SOURCES = 3;
   localparam int NUM_SETS    = 1 << SET_BITS;
   localparam int TAG_W       = ADDR_W - SET_BITS;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 485;

   // one micro-op as offered on the request channel
   typedef struct packed {
      bit                              cmd;
      bit [ADDR_W-1:0]                 op_addr;
      bit                              is_load;
      bit                              is_store;
      bit [PROD_FIELDS-1:0][ADDR_W-1:0] prod_addr;
      bit [PROD_FIELDS-1:0]            prod_valid;
   } slice_req_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_cmd = CMD_QUERY;
   logic [ADDR_W-1:0]   req_op_addr = '0;
   logic                req_is_load = 1'b0;
   logic                req_is_store = 1'b0;
   logic [ADDR_W-1:0]   req_producer_addr_0 = '0;
   logic                req_producer_valid_0 = 1'b0;
   logic [ADDR_W-1:0]   req_producer_addr_1 = '0;
   logic                req_producer_valid_1 = 1'b0;
   logic [ADDR_W-1:0]   req_producer_addr_2 = '0;
   logic                req_producer_valid_2 = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_in_slice;

   // micro-ops waiting to be offered, in_slice bits waiting to come back
   slice_req_type pending_ops[$];
   bit            expected_in_slice[$];

   // predictor copy of the table
   bit [TAG_W-1:0]   slice_tag   [NUM_SETS*WAYS];
   bit [STAMP_W-1:0] slice_stamp [NUM_SETS*WAYS];
   bit [STAMP_W-1:0] touch_count;

   int  error_count = 0;
   int  accepted_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  req_taken = 1'b0;

   instruction_slice_table_core #(
      .SET_BITS    (SET_BITS),
      .WAYS        (WAYS),
      .MAX_SOURCES (MAX_SOURCES)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_op_addr          (req_op_addr),
      .req_is_load          (req_is_load),
      .req_is_store         (req_is_store),
      .req_producer_addr_0  (req_producer_addr_0),
      .req_producer_valid_0 (req_producer_valid_0),
      .req_producer_addr_1  (req_producer_addr_1),
      .req_producer_valid_1 (req_producer_valid_1),
      .req_producer_addr_2  (req_producer_addr_2),
      .req_producer_valid_2 (req_producer_valid_2),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_in_slice         (rsp_in_slice)
   );

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // tag lookup in the predictor table
   function automatic bit slice_hit(bit [ADDR_W-1:0] a);
      int base;
      bit found;
      base = int'(a[SET_BITS-1:0]) * WAYS;
      found = 1'b0;
      for (int w = 0; w < WAYS; w++)
         if (slice_tag[base+w] == a[ADDR_W-1:SET_BITS]) found = 1'b1;
      return found;
   endfunction

   // refresh a hit, else replace the least recently used way
   function automatic void touch_addr(bit [ADDR_W-1:0] a);
      int base;
      int victim;
      bit [TAG_W-1:0] t;
      base = int'(a[SET_BITS-1:0]) * WAYS;
      t = a[ADDR_W-1:SET_BITS];
      victim = 0;
      for (int w = 0; w < WAYS; w++) begin
         if (slice_tag[base+w] == t) begin
            slice_stamp[base+w] = touch_count;
            touch_count++;
            return;
         end
      end
      for (int w = 1; w < WAYS; w++)
         if (slice_stamp[base+w] < slice_stamp[base+victim]) victim = w;
      slice_tag[base+victim] = t;
      slice_stamp[base+victim] = touch_count;
      touch_count++;
   endfunction

   // in_slice prediction, then training where the op qualifies
   function automatic bit predict_in_slice(slice_req_type r);
      bit in_slice;
      if (r.is_load) in_slice = 1'b1;
      else if (r.is_store) in_slice = 1'b0;
      else in_slice = slice_hit(r.op_addr);
      if (r.cmd == CMD_TRAIN && (r.is_store || in_slice)) begin
         touch_addr(r.op_addr);
         for (int i = 0; i < PROD_FIELDS && i < MAX_SOURCES; i++)
            if (r.prod_valid[i]) touch_addr(r.prod_addr[i]);
      end
      return in_slice;
   endfunction

   function automatic bit [ADDR_W-1:0] addr_at(bit [TAG_W-1:0] t, int set_idx);
      return {t, set_idx[SET_BITS-1:0]};
   endfunction

   function automatic slice_req_type make_op(bit cmd, bit [ADDR_W-1:0] op, bit ld, bit st,
                                             bit [ADDR_W-1:0] p0, bit v0,
                                             bit [ADDR_W-1:0] p1, bit v1,
                                             bit [ADDR_W-1:0] p2, bit v2);
      slice_req_type r;
      r.cmd = cmd;
      r.op_addr = op;
      r.is_load = ld;
      r.is_store = st;
      r.prod_addr = {p2, p1, p0};
      r.prod_valid = {v2, v1, v0};
      return r;
   endfunction

   // addresses mostly from a few sets and tags so that sets fill and evict
   function automatic bit [ADDR_W-1:0] rand_addr();
      int pick;
      int set_idx;
      bit [TAG_W-1:0] t;
      pick = $urandom_range(0, 99);
      if (pick < 8) return ADDR_W'({$urandom, $urandom});
      set_idx = (pick < 25) ? $urandom_range(0, NUM_SETS - 1) : $urandom_range(0, 3);
      case ($urandom_range(0, 5))
         0: t = '0;
         1: t = TAG_W'(1);
         2: t = TAG_W'(2);
         3: t = TAG_W'(3);
         4: t = '1;
         default: t = {TAG_W{1'b1}} >> 1;
      endcase
      return addr_at(t, set_idx);
   endfunction

   function automatic slice_req_type rand_op();
      slice_req_type r;
      int kind;
      kind = $urandom_range(0, 99);
      r.cmd = ($urandom_range(0, 99) < 70) ? CMD_TRAIN : CMD_QUERY;
      r.is_store = (kind < 30) || (kind >= 45 && kind < 50);
      r.is_load = (kind >= 30 && kind < 50);
      r.op_addr = rand_addr();
      for (int i = 0; i < PROD_FIELDS; i++) begin
         r.prod_addr[i] = rand_addr();
         r.prod_valid[i] = ($urandom_range(0, 99) < 60);
      end
      return r;
   endfunction

   // request driver: new items at the falling edge, valid held until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            slice_req_type r;
            r = pending_ops.pop_front();
            req_valid            <= 1'b1;
            req_cmd              <= r.cmd;
            req_op_addr          <= r.op_addr;
            req_is_load          <= r.is_load;
            req_is_store         <= r.is_store;
            req_producer_addr_0  <= r.prod_addr[0];
            req_producer_valid_0 <= r.prod_valid[0];
            req_producer_addr_1  <= r.prod_addr[1];
            req_producer_valid_1 <= r.prod_valid[1];
            req_producer_addr_2  <= r.prod_addr[2];
            req_producer_valid_2 <= r.prod_valid[2];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long response hold-off once some traffic has gone through
   always @(negedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && accepted_count >= 40) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response ready with random stalls
   always @(negedge clock) begin
      if (reset || hold_left != 0) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // monitor: check responses, predict accepted requests
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_in_slice.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual in_slice %0b",
                        $time, rsp_in_slice);
               error_count++;
            end else begin
               bit exp_bit;
               exp_bit = expected_in_slice.pop_front();
               if (rsp_in_slice !== exp_bit) begin
                  $display("%0t: in_slice mismatch, expected %0b, actual %0b",
                           $time, exp_bit, rsp_in_slice);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_in_slice.push_back(predict_in_slice(make_op(
               req_cmd, req_op_addr, req_is_load, req_is_store,
               req_producer_addr_0, req_producer_valid_0,
               req_producer_addr_1, req_producer_valid_1,
               req_producer_addr_2, req_producer_valid_2)));
            accepted_count++;
         end
      end
   end

   task automatic drain_pending();
      while (pending_ops.size() != 0) @(negedge clock);
   endtask

   // stimulus and end of run
   initial begin
      bit [ADDR_W-1:0] a_addr, b_addr, c_addr, d_addr, ones;
      ones = '1;
      a_addr = addr_at(7, 5);
      b_addr = addr_at(9, 5);
      c_addr = addr_at(11, 5);
      d_addr = addr_at(13, 6);
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset tags of zero hit, full-ones address misses
      pending_ops.push_back(make_op(CMD_QUERY, '0, 0, 0, '0, 0, '0, 0, '0, 0));
      pending_ops.push_back(make_op(CMD_QUERY, ones, 0, 0, ones, 1, ones, 1, ones, 1));
      // load, store, both
      pending_ops.push_back(make_op(CMD_QUERY, ones, 1, 0, '0, 0, '0, 0, '0, 0));
      pending_ops.push_back(make_op(CMD_QUERY, '0, 0, 1, '0, 0, '0, 0, '0, 0));
      pending_ops.push_back(make_op(CMD_QUERY, ones, 1, 1, '0, 0, '0, 0, '0, 0));
      // an untrained op that misses does not train
      pending_ops.push_back(make_op(CMD_TRAIN, ones, 0, 0, d_addr, 1, '0, 0, '0, 0));
      pending_ops.push_back(make_op(CMD_QUERY, ones, 0, 0, '0, 0, '0, 0, '0, 0));
      pending_ops.push_back(make_op(CMD_QUERY, d_addr, 0, 0, '0, 0, '0, 0, '0, 0));
      // store trains itself and its producers, ties go to the first way
      pending_ops.push_back(make_op(CMD_TRAIN, a_addr, 0, 1, b_addr, 1, d_addr, 1, ones, 0));
      pending_ops.push_back(make_op(CMD_QUERY, a_addr, 0, 0, '0, 0, '0, 0, '0, 0));
      pending_ops.push_back(make_op(CMD_QUERY, b_addr, 0, 0, '0, 0, '0, 0, '0, 0));
      pending_ops.push_back(make_op(CMD_QUERY, d_addr, 0, 0, '0, 0, '0, 0, '0, 0));
      pending_ops.push_back(make_op(CMD_QUERY, ones, 0, 0, '0, 0, '0, 0, '0, 0));
      // refresh a, then c evicts b
      pending_ops.push_back(make_op(CMD_TRAIN, a_addr, 0, 1, '0, 0, '0, 0, '0, 0));
      pending_ops.push_back(make_op(CMD_TRAIN, c_addr, 0, 1, '0, 0, '0, 0, '0, 0));
      pending_ops.push_back(make_op(CMD_QUERY, a_addr, 0, 0, '0, 0, '0, 0, '0, 0));
      pending_ops.push_back(make_op(CMD_QUERY, b_addr, 0, 0, '0, 0, '0, 0, '0, 0));
      pending_ops.push_back(make_op(CMD_QUERY, c_addr, 0, 0, '0, 0, '0, 0, '0, 0));
      // predicted op trains, load plus store trains
      pending_ops.push_back(make_op(CMD_TRAIN, c_addr, 0, 0, b_addr, 0, '0, 0, b_addr, 1));
      pending_ops.push_back(make_op(CMD_TRAIN, ones, 1, 1, ones, 1, a_addr, 1, c_addr, 1));
      pending_ops.push_back(make_op(CMD_QUERY, ones, 0, 0, '0, 0, '0, 0, '0, 0));
      pending_ops.push_back(make_op(CMD_QUERY, b_addr, 0, 0, '0, 0, '0, 0, '0, 0));

      // random phases: none, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 88; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 88; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) pending_ops.push_back(rand_op());
         drain_pending();
      end

      // let the last request reach the port before waiting on it
      @(negedge clock);
      while (req_valid || expected_in_slice.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
